// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check on every clock edge, skipped while reset is asserted.
`define ASSERT_AR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_AR(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: sv/sv39m_pkg.sv
`timescale 1ns / 1ps

package sv39m_pkg;

	localparam int NUM_PAGES        = 64;
	localparam int ENTRIES_PER_PAGE = 512;
	localparam int VPN_W            = $clog2(ENTRIES_PER_PAGE);
	localparam int IDX_W            = $clog2(NUM_PAGES);
	localparam int ADDR_W           = IDX_W + VPN_W;
	localparam int STORE_DEPTH      = NUM_PAGES * ENTRIES_PER_PAGE;
	localparam int POOL_W           = 7;
	localparam int NFP_W            = $clog2(NUM_PAGES + 1);
	localparam int LIM_W            = (NFP_W > POOL_W) ? NFP_W : POOL_W;
	localparam int PPN_W            = 44;
	localparam int VA_W             = 39;
	localparam int PTE_W            = 64;
	localparam int CFG_W            = 44;
	localparam int PTE_PPN_LSB      = 10;
	localparam int PTE_PPN_MSB      = PTE_PPN_LSB + PPN_W - 1;
	localparam int NUM_SLOTS        = 3;
	localparam int SLOT_W           = 2;

	localparam logic [PTE_PPN_LSB-1:0] FLAGS_TABLE = 10'h0D1;
	localparam logic [PTE_PPN_LSB-1:0] FLAGS_LEAF  = 10'h0DF;
	localparam logic [SLOT_W-1:0]      SLOT_LEAF   = SLOT_W'(NUM_SLOTS - 1);
	localparam logic [LIM_W-1:0]       POOL_RESET  = LIM_W'(64);

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_PAGE     = 2'd1,
		ST_OUT_OF_POOL = 2'd2
	} status_t;

	typedef enum logic {
		REG_POOL_BASE  = 1'b0,
		REG_POOL_PAGES = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_READ,
		S_EVAL,
		S_LEAF,
		S_WRITE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              clear;
		logic              latch;
		logic              check;
		logic              rd;
		logic              eval;
		logic              leaf;
		logic              wr;
		logic              load_out;
		logic              lvl;
		logic [SLOT_W-1:0] widx;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_map;
		logic fail;
		logic out_busy;
	} sts_t;

endpackage

// File: sv/sv39m_ctrl.sv
`timescale 1ns / 1ps

module sv39m_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sv39m_pkg::sts_t   sts,
	output sv39m_pkg::cmd_t   cmd
);

	localparam int SLOT_W = sv39m_pkg::SLOT_W;

	sv39m_pkg::state_t state_q, state_d;
	logic lvl_q, lvl_d;
	logic [sv39m_pkg::SLOT_W-1:0] widx_q, widx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sv39m_pkg::S_CLEAR;
			lvl_q   <= 1'b0;
			widx_q  <= '0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
			widx_q  <= widx_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		lvl_d    = lvl_q;
		widx_d   = widx_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.lvl  = lvl_q;
		cmd.widx = widx_q;
		unique case (state_q)
			sv39m_pkg::S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) state_d = sv39m_pkg::S_IDLE;
			end
			sv39m_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = sv39m_pkg::S_CHECK;
				end
			end
			sv39m_pkg::S_CHECK: begin
				cmd.check = 1'b1;
				lvl_d     = 1'b0;
				if (!sts.is_map || sts.fail) state_d = sv39m_pkg::S_DONE;
				else state_d = sv39m_pkg::S_READ;
			end
			sv39m_pkg::S_READ: begin
				cmd.rd  = 1'b1;
				state_d = sv39m_pkg::S_EVAL;
			end
			sv39m_pkg::S_EVAL: begin
				cmd.eval = 1'b1;
				priority if (sts.fail) begin
					state_d = sv39m_pkg::S_DONE;
				end else if (lvl_q) begin
					state_d = sv39m_pkg::S_LEAF;
				end else begin
					lvl_d   = 1'b1;
					state_d = sv39m_pkg::S_READ;
				end
			end
			sv39m_pkg::S_LEAF: begin
				cmd.leaf = 1'b1;
				widx_d   = '0;
				if (sts.fail) state_d = sv39m_pkg::S_DONE;
				else state_d = sv39m_pkg::S_WRITE;
			end
			sv39m_pkg::S_WRITE: begin
				cmd.wr = 1'b1;
				if (widx_q == sv39m_pkg::SLOT_LEAF) state_d = sv39m_pkg::S_DONE;
				else widx_d = widx_q + SLOT_W'(1);
			end
			sv39m_pkg::S_DONE: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = sv39m_pkg::S_IDLE;
				end
			end
			default: state_d = sv39m_pkg::S_CLEAR;
		endcase
	end

endmodule

// File: sv/sv39m_dp.sv
`timescale 1ns / 1ps

module sv39m_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sv39m_pkg::cmd_t               cmd,
	output sv39m_pkg::sts_t               sts,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [sv39m_pkg::CFG_W-1:0]   cfg_data,
	input  logic                          req_type,
	input  logic [sv39m_pkg::VA_W-1:0]    virt_addr,
	input  logic [sv39m_pkg::PPN_W-1:0]   root_ppn,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [sv39m_pkg::PPN_W-1:0]   page_ppn,
	output logic [1:0]                    tables_made,
	output logic [1:0]                    status
);

	localparam int PPN_W  = sv39m_pkg::PPN_W;
	localparam int LIM_W  = sv39m_pkg::LIM_W;
	localparam int IDX_W  = sv39m_pkg::IDX_W;
	localparam int ADDR_W = sv39m_pkg::ADDR_W;
	localparam int PTE_W  = sv39m_pkg::PTE_W;
	localparam logic [sv39m_pkg::POOL_W-1:0] POOL_RESET_7 =
		sv39m_pkg::POOL_W'(sv39m_pkg::POOL_RESET);

	// configuration
	logic [PPN_W-1:0]              pool_base_q;
	logic [sv39m_pkg::POOL_W-1:0]  pool_pages_q;

	// page store
	logic [PTE_W-1:0] mem [sv39m_pkg::STORE_DEPTH];
	logic [PTE_W-1:0] mem_rd_q;
	logic             mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [PTE_W-1:0]  mem_wdata;
	logic [ADDR_W-1:0] clr_q;

	// request and walk state
	logic                         req_type_q;
	logic [sv39m_pkg::VA_W-1:0]   va_q;
	logic [PPN_W-1:0]             root_q;
	logic [IDX_W-1:0]             cur_q;
	logic [LIM_W-1:0]             nfp_q, nfpw_q;
	logic [ADDR_W-1:0]            rd_addr_q;
	logic                         fwd_q;
	logic [1:0]                   made_q;
	logic [PPN_W-1:0]             res_ppn_q;
	sv39m_pkg::status_t           res_status_q;

	// pending writes: two table entries and the leaf
	logic [ADDR_W-1:0] slot_addr_q [sv39m_pkg::NUM_SLOTS];
	logic [PTE_W-1:0]  slot_val_q  [sv39m_pkg::NUM_SLOTS];
	logic [sv39m_pkg::NUM_SLOTS-1:0] slot_vld_q;

	// output register
	logic               out_valid_q;
	logic [PPN_W-1:0]   page_ppn_q;
	logic [1:0]         tables_made_q;
	sv39m_pkg::status_t status_q;

	logic [LIM_W-1:0]  lim;
	logic [PTE_W-1:0]  pte;
	logic [PPN_W-1:0]  sub_src, sub_off, alloc_ppn;
	logic [LIM_W-1:0]  alloc_src;
	logic              off_bad, no_page;
	logic [ADDR_W-1:0] rd_addr;
	logic [sv39m_pkg::VPN_W-1:0] vpn_sel;

	assign lim = (LIM_W'(pool_pages_q) < LIM_W'(sv39m_pkg::NUM_PAGES))
		? LIM_W'(pool_pages_q) : LIM_W'(sv39m_pkg::NUM_PAGES);

	// forward a table entry written earlier in this walk but not yet stored
	assign pte       = fwd_q ? slot_val_q[0] : mem_rd_q;
	assign sub_src   = cmd.check ? root_q : pte[sv39m_pkg::PTE_PPN_MSB:sv39m_pkg::PTE_PPN_LSB];
	assign sub_off   = sub_src - pool_base_q;
	assign off_bad   = sub_off >= PPN_W'(lim);
	assign alloc_src = cmd.check ? nfp_q : nfpw_q;
	assign no_page   = alloc_src >= lim;
	assign alloc_ppn = pool_base_q + PPN_W'(alloc_src);
	assign vpn_sel   = cmd.lvl ? va_q[29:21] : va_q[38:30];
	assign rd_addr   = {cur_q, vpn_sel};

	always_comb begin
		sts.clr_last = (clr_q == ADDR_W'(sv39m_pkg::STORE_DEPTH - 1));
		sts.is_map   = req_type_q;
		sts.out_busy = out_valid_q && !out_ready;
		sts.fail     = (cmd.check && (req_type_q ? off_bad : no_page))
			|| (cmd.eval && (pte[0] ? off_bad : no_page))
			|| (cmd.leaf && no_page);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		if (cmd.clear) begin
			mem_we = 1'b1;
		end else if (cmd.wr) begin
			mem_we    = slot_vld_q[cmd.widx];
			mem_waddr = slot_addr_q[cmd.widx];
			mem_wdata = slot_val_q[cmd.widx];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (cmd.rd) mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= '0;
			pool_pages_q <= POOL_RESET_7;
			clr_q        <= '0;
			nfp_q        <= '0;
			slot_vld_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (sv39m_pkg::cfg_reg_t'(cfg_idx))
					sv39m_pkg::REG_POOL_BASE:  pool_base_q  <= cfg_data[PPN_W-1:0];
					sv39m_pkg::REG_POOL_PAGES: pool_pages_q <= cfg_data[sv39m_pkg::POOL_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clear) clr_q <= clr_q + ADDR_W'(1);
			if (cmd.check) begin
				slot_vld_q <= '0;
				if (!req_type_q && !no_page) nfp_q <= nfp_q + LIM_W'(1);
			end
			if (cmd.eval && !sts.fail && !pte[0]) slot_vld_q[{1'b0, cmd.lvl}] <= 1'b1;
			if (cmd.leaf && !no_page) begin
				slot_vld_q[sv39m_pkg::SLOT_LEAF] <= 1'b1;
				nfp_q <= nfpw_q + LIM_W'(1);
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_type_q <= req_type;
			va_q       <= virt_addr;
			root_q     <= root_ppn;
		end
		if (cmd.check) begin
			made_q       <= '0;
			nfpw_q       <= nfp_q;
			cur_q        <= sub_off[IDX_W-1:0];
			if (req_type_q) begin
				if (off_bad) res_status_q <= sv39m_pkg::ST_OUT_OF_POOL;
				else res_status_q <= sv39m_pkg::ST_OK;
			end else begin
				res_ppn_q <= alloc_ppn;
				if (no_page) res_status_q <= sv39m_pkg::ST_NO_PAGE;
				else res_status_q <= sv39m_pkg::ST_OK;
			end
		end
		if (cmd.rd) begin
			rd_addr_q <= rd_addr;
			fwd_q     <= slot_vld_q[0] && (slot_addr_q[0] == rd_addr);
		end
		if (cmd.eval) begin
			if (sts.fail) begin
				res_status_q <= pte[0] ? sv39m_pkg::ST_OUT_OF_POOL : sv39m_pkg::ST_NO_PAGE;
			end else if (pte[0]) begin
				cur_q <= sub_off[IDX_W-1:0];
			end else begin
				slot_addr_q[{1'b0, cmd.lvl}] <= rd_addr_q;
				slot_val_q[{1'b0, cmd.lvl}]  <= {10'b0, alloc_ppn, sv39m_pkg::FLAGS_TABLE};
				cur_q  <= alloc_src[IDX_W-1:0];
				nfpw_q <= nfpw_q + LIM_W'(1);
				made_q <= made_q + 2'd1;
			end
		end
		if (cmd.leaf) begin
			if (no_page) begin
				res_status_q <= sv39m_pkg::ST_NO_PAGE;
			end else begin
				slot_addr_q[sv39m_pkg::SLOT_LEAF] <= {cur_q, va_q[20:12]};
				slot_val_q[sv39m_pkg::SLOT_LEAF]  <= {10'b0, alloc_ppn, sv39m_pkg::FLAGS_LEAF};
				res_ppn_q <= alloc_ppn;
			end
		end
		if (cmd.load_out) begin
			status_q      <= res_status_q;
			page_ppn_q    <= (res_status_q == sv39m_pkg::ST_OK) ? res_ppn_q : '0;
			tables_made_q <= (res_status_q == sv39m_pkg::ST_OK) ? made_q : 2'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign page_ppn    = page_ppn_q;
	assign tables_made = tables_made_q;
	assign status      = status_q;

endmodule

// File: sv/sv39_map_with_page_alloc.sv
// Sequence: a bare allocation checks the pool and finishes; a map request reads the two
// upper-level entries (each a dependent page-store read followed by evaluation), stages
// the leaf, then steps through three write slots on the single store write port, and
// finishes early on an error. The next item is accepted while the previous result waits
// in the output register. Reset: asynchronous, active low; afterwards a clearing pass
// zeroes all 32768 page-store entries, one entry per cycle, no item taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sv39_map_with_page_alloc (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [sv39m_pkg::CFG_W-1:0]   cfg_data,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [sv39m_pkg::VA_W-1:0]    virt_addr,
	input  logic [sv39m_pkg::PPN_W-1:0]   root_ppn,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sv39m_pkg::PPN_W-1:0]   page_ppn,
	output logic [1:0]                    tables_made,
	output logic [1:0]                    status
);

	// The controller sequences clear, check, walk, leaf and commit; the
	// datapath holds the page store, the allocation pointer and the pending
	// writes. Writes are staged during the walk and committed only once the
	// whole request has succeeded, so a failed request leaves no trace.
	sv39m_pkg::cmd_t cmd;
	sv39m_pkg::sts_t sts;
	// result flags an error / result carries no page and no tables
	logic            out_err;
	logic            out_empty;

	sv39m_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sv39m_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.req_type    (req_type),
		.virt_addr   (virt_addr),
		.root_ppn    (root_ppn),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.page_ppn    (page_ppn),
		.tables_made (tables_made),
		.status      (status)
	);

	assign out_err   = out_valid && (status != sv39m_pkg::ST_OK);
	assign out_empty = (page_ppn == '0) && (tables_made == 2'd0);

	// only one transaction is in flight at a time
	`ASSERT_AR(a_one_in_flight, (in_valid && in_ready) |=> !in_ready, "second request taken mid-walk")
	// a finished result never overwrites one still waiting to be taken
	`ASSERT_ALWAYS(a_no_overwrite, cmd.load_out |-> !sts.out_busy, "pending result overwritten")
	// a failed request reports no page and no tables
	`ASSERT_AR(a_err_zero, out_err |-> out_empty, "error result carries data")

endmodule

// File: tb/sv39_map_checker.sv
`timescale 1ns / 1ps

module sv39_map_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_idx,
	input  logic [sv39m_pkg::CFG_W-1:0] cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        req_type,
	input  logic [sv39m_pkg::VA_W-1:0]  virt_addr,
	input  logic [sv39m_pkg::PPN_W-1:0] root_ppn,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [sv39m_pkg::PPN_W-1:0] page_ppn,
	input  logic [1:0]                  tables_made,
	input  logic [1:0]                  status,
	output int                          accepted,
	output int                          pending,
	output int                          fail_count
);
	import sv39m_pkg::*;

	typedef struct packed {
		logic [PPN_W-1:0] ppn;
		logic [1:0]       made;
		status_t          st;
	} alloc_result_t;

	// shadow of the page store, the pool cursor and both registers
	logic [PTE_W-1:0]  pte_mem [STORE_DEPTH];
	logic [NFP_W-1:0]  free_page;
	logic [PPN_W-1:0]  base_ppn;
	logic [POOL_W-1:0] pool_pages;
	alloc_result_t     expected_q [$];
	alloc_result_t     head;

	// Allocate a bare page, or walk the three levels and map, rolling back on any error.
	function automatic alloc_result_t predict_alloc(input logic is_map,
			input logic [VA_W-1:0] va, input logic [PPN_W-1:0] root);
		alloc_result_t     res;
		logic [LIM_W-1:0]  limit;
		logic [NFP_W-1:0]  saved_free;
		logic [PPN_W-1:0]  off;
		logic [IDX_W-1:0]  cur;
		logic [IDX_W-1:0]  nxt;
		logic [VPN_W-1:0]  vpn;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] undo_addr [NUM_SLOTS];
		logic [PTE_W-1:0]  undo_val [NUM_SLOTS];
		logic [1:0]        tables;
		int                n_undo;
		int                lvl;
		int                k;

		res.ppn = '0;
		res.made = '0;
		res.st = ST_OK;
		tables = '0;
		n_undo = 0;
		nxt = '0;
		limit = (LIM_W'(pool_pages) < LIM_W'(NUM_PAGES)) ? LIM_W'(pool_pages)
				: LIM_W'(NUM_PAGES);

		if (!is_map) begin
			if (LIM_W'(free_page) < limit) begin
				res.ppn = base_ppn + PPN_W'(free_page);
				free_page++;
			end else begin
				res.st = ST_NO_PAGE;
			end
			return res;
		end

		saved_free = free_page;
		off = root - base_ppn;
		if (off >= PPN_W'(limit))
			res.st = ST_OUT_OF_POOL;
		cur = off[IDX_W-1:0];

		for (lvl = 0; lvl < 2 && res.st == ST_OK; lvl++) begin
			vpn = (lvl == 0) ? va[38:30] : va[29:21];
			addr = {cur, vpn};
			if (pte_mem[addr][0]) begin
				off = pte_mem[addr][PTE_PPN_MSB:PTE_PPN_LSB] - base_ppn;
				if (off >= PPN_W'(limit))
					res.st = ST_OUT_OF_POOL;
				else
					nxt = off[IDX_W-1:0];
			end else if (LIM_W'(free_page) >= limit) begin
				res.st = ST_NO_PAGE;
			end else begin
				nxt = free_page[IDX_W-1:0];
				free_page++;
				undo_addr[n_undo] = addr;
				undo_val[n_undo] = pte_mem[addr];
				n_undo++;
				pte_mem[addr] = {10'b0, PPN_W'(base_ppn + PPN_W'(nxt)), FLAGS_TABLE};
				tables++;
			end
			cur = nxt;
		end

		if (res.st == ST_OK) begin
			if (LIM_W'(free_page) >= limit) begin
				res.st = ST_NO_PAGE;
			end else begin
				addr = {cur, va[20:12]};
				res.ppn = base_ppn + PPN_W'(free_page);
				undo_addr[n_undo] = addr;
				undo_val[n_undo] = pte_mem[addr];
				n_undo++;
				pte_mem[addr] = {10'b0, res.ppn, FLAGS_LEAF};
				free_page++;
			end
		end

		if (res.st != ST_OK) begin
			for (k = n_undo - 1; k >= 0; k--)
				pte_mem[undo_addr[k]] = undo_val[k];
			free_page = saved_free;
			res.ppn = '0;
			tables = '0;
		end
		res.made = tables;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < STORE_DEPTH; a++)
				pte_mem[a] = '0;
			free_page = '0;
			base_ppn = '0;
			pool_pages = POOL_RESET;
			expected_q.delete();
			accepted = 0;
			pending = 0;
			fail_count = 0;
		end else begin
			// retire a result before queuing a new request at the same edge
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result: page_ppn %h tables_made %0d status %0d",
						page_ppn, tables_made, status);
					fail_count++;
				end else begin
					head = expected_q.pop_front();
					if (page_ppn !== head.ppn) begin
						$error("page_ppn: expected %h, got %h", head.ppn, page_ppn);
						fail_count++;
					end
					if (tables_made !== head.made) begin
						$error("tables_made: expected %0d, got %0d", head.made, tables_made);
						fail_count++;
					end
					if (status !== head.st) begin
						$error("status: expected %0d, got %0d", head.st, status);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_q.push_back(predict_alloc(req_type, virt_addr, root_ppn));
				accepted++;
			end
			if (cfg_we) begin
				if (cfg_idx == REG_POOL_BASE)
					base_ppn = cfg_data[PPN_W-1:0];
				else
					pool_pages = cfg_data[POOL_W-1:0];
			end
			pending = expected_q.size();
		end
	end

endmodule

// File: tb/tb_sv39_map_with_page_alloc.sv
`timescale 1ns / 1ps

module tb_sv39_map_with_page_alloc;
	import sv39m_pkg::*;

	// Slowest legal run: the store clearing pass after reset, then every
	// transaction waiting out the longest sender gap, the walk and the longest
	// receiver stall. The limit sits several times above that.
	localparam int CYCLE_LIMIT = 1_000_000;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_MAP   = 1'b1;

	// A pool base just below the top of the page-number space, so that page
	// numbers wrap to zero inside the pool.
	localparam logic [PPN_W-1:0] BASE_WRAP = 44'hFFF_FFFF_FFF8;
	localparam logic [PPN_W-1:0] PPN_MAX   = 44'hFFF_FFFF_FFFF;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic             cfg_idx = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             req_type = 1'b0;
	logic [VA_W-1:0]  virt_addr = '0;
	logic [PPN_W-1:0] root_ppn = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [PPN_W-1:0] page_ppn;
	logic [1:0]       tables_made;
	logic [1:0]       status;

	int               accepted;
	int               pending;
	int               fail_count;
	int               cycles = 0;
	int               stall_left = 0;
	// while set, neither side idles
	logic             burst = 1'b0;
	// pool base as last written, used to aim roots into the pool
	logic [PPN_W-1:0] pool_base = '0;

	sv39_map_with_page_alloc dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.virt_addr   (virt_addr),
		.root_ppn    (root_ppn),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.page_ppn    (page_ppn),
		.tables_made (tables_made),
		.status      (status)
	);

	sv39_map_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.virt_addr   (virt_addr),
		.root_ppn    (root_ppn),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.page_ppn    (page_ppn),
		.tables_made (tables_made),
		.status      (status),
		.accepted    (accepted),
		.pending     (pending),
		.fail_count  (fail_count)
	);

	always #5 clk = ~clk;

	// Hard stop in case a transaction never completes.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("sv39_map_with_page_alloc regression: fail");
			$finish;
		end
	end

	// Idle lengths from three bands: the shortest most often, the middle sometimes, the longest rarely.
	function automatic int pick_stall();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		if (r < 93)
			return $urandom_range(3, 6);
		return $urandom_range(15, 50);
	endfunction

	// Favor a few table indexes so walks keep landing on existing PTEs.
	function automatic logic [VPN_W-1:0] pick_vpn();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return '0;
		if (r < 45)
			return '1;
		if (r < 65)
			return VPN_W'($urandom_range(0, 3));
		return VPN_W'($urandom);
	endfunction

	// Result side: hold ready low for a random stretch, then release it.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!burst && $urandom_range(0, 99) < 25) begin
			out_ready <= 1'b0;
			stall_left <= pick_stall() - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Drop valid and hold until every outstanding result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	// Write both pool registers, only with the block idle.
	task automatic set_pool(input logic [PPN_W-1:0] base, input logic [POOL_W-1:0] pages);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= REG_POOL_BASE;
		cfg_data <= CFG_W'(base);
		@(negedge clk);
		cfg_idx <= REG_POOL_PAGES;
		cfg_data <= CFG_W'(pages);
		@(negedge clk);
		cfg_we <= 1'b0;
		pool_base = base;
	endtask

	// Present one request after an optional gap and hold it until the
	// transaction is seen. Returns on the falling edge after acceptance, with
	// valid still high so that back-to-back requests need no toggle.
	task automatic send(input logic kind, input logic [VA_W-1:0] va,
			input logic [PPN_W-1:0] root);
		int gap;
		int target;
		if ($urandom_range(0, 39) == 0)
			burst = ~burst;
		gap = (burst || $urandom_range(0, 99) < 45) ? 0 : pick_stall();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		virt_addr <= va;
		root_ppn <= root;
		target = accepted + 1;
		do
			@(negedge clk);
		while (accepted != target);
	endtask

	// Mostly map requests rooted at the first few pool pages; the rest hit
	// the pool edge, fall just below the base, or are pure noise.
	task automatic send_random();
		logic [PPN_W-1:0] root;
		logic [VA_W-1:0]  va;
		int               r;
		r = $urandom_range(0, 99);
		if (r < 55)
			root = pool_base + PPN_W'($urandom_range(0, 3));
		else if (r < 80)
			root = pool_base + PPN_W'($urandom_range(0, 70));
		else if (r < 90)
			root = pool_base - PPN_W'($urandom_range(1, 4));
		else
			root = PPN_W'({$urandom, $urandom});
		va = {pick_vpn(), pick_vpn(), VPN_W'($urandom), 12'($urandom)};
		send(($urandom_range(0, 99) < 12) ? REQ_ALLOC : REQ_MAP, va, root);
	endtask

	task automatic run_phase(input logic [PPN_W-1:0] base, input logic [POOL_W-1:0] pages,
			input int n_items);
		set_pool(base, pages);
		repeat (n_items) begin
			// now and then let the block run dry mid-phase
			if ($urandom_range(0, 99) == 0)
				drain();
			send_random();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values of both registers; waits out the clearing pass.
		send(REQ_ALLOC, '0, '0);

		// Pool of 20 pages whose numbers wrap past zero.
		set_pool(BASE_WRAP, 7'd20);
		send(REQ_MAP, 39'h0, BASE_WRAP);                       // two tables + leaf
		send(REQ_MAP, 39'h7F_FFFF_FFFF, BASE_WRAP);            // top indexes at every level
		send(REQ_MAP, 39'h1000, BASE_WRAP);                    // reuse both tables
		send(REQ_MAP, 39'h0, BASE_WRAP);                       // overwrite a valid leaf
		send(REQ_MAP, 39'h55_5555_5555, BASE_WRAP + 44'd19);   // root on last, unallocated page
		send(REQ_MAP, 39'h2A_AAAA_AAAA, BASE_WRAP + 44'd20);   // root one past the pool
		send(REQ_MAP, 39'h0, BASE_WRAP - 44'd1);               // root just below the base
		send(REQ_MAP, 39'h12_3456_789A, PPN_MAX);              // root at top page number
		send(REQ_MAP, 39'h0_2AB4_5FFF, BASE_WRAP + 44'd2);     // leaf PTE followed as a table
		send(REQ_ALLOC, 39'h7F_FFFF_FFFF, PPN_MAX);            // map fields ignored
		send(REQ_MAP, 39'h0_8000_0ABC, BASE_WRAP);             // runs dry after two tables
		send(REQ_MAP, 39'h0_4000_0000, BASE_WRAP + 44'd2);     // one table, takes last page
		send(REQ_ALLOC, '0, '0);                               // pool exhausted
		send(REQ_MAP, 39'h3000, BASE_WRAP);                    // full path, no leaf page

		// Shrink the pool below pages already handed out.
		set_pool(BASE_WRAP, 7'd10);
		send(REQ_MAP, 39'h12_3456_789A, BASE_WRAP + 44'd7);    // upper PTE leaves the pool
		send(REQ_MAP, 39'h0_2AB4_5FFF, BASE_WRAP + 44'd2);     // second-level PTE leaves it
		send(REQ_MAP, 39'h0, BASE_WRAP);

		// Empty pool.
		set_pool(BASE_WRAP, 7'd0);
		send(REQ_ALLOC, '0, '0);
		send(REQ_MAP, 39'h0, BASE_WRAP);

		// Random phases; each one shifts how stored PTEs relate to the pool.
		run_phase(BASE_WRAP, 7'd64, 500);
		run_phase(BASE_WRAP + 44'd2, 7'd127, 300);
		run_phase('0, 7'd64, 250);
		run_phase(PPN_MAX, 7'd1, 200);
		run_phase(PPN_W'({$urandom, $urandom}), 7'd33, 150);
		run_phase(BASE_WRAP, 7'd64, 250);

		drain();
		// catch any stray result after the last expected one
		repeat (24) @(negedge clk);
		if (fail_count == 0)
			$display("sv39_map_with_page_alloc regression: pass");
		else
			$display("sv39_map_with_page_alloc regression: fail");
		$finish;
	end

endmodule
